>>> src/crt_reconstruct_core_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef CRT_RECONSTRUCT_CORE_ASSERT_SVH
`define CRT_RECONSTRUCT_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define CRT_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("crt assertion failed");

// Next-cycle implication.
`define CRT_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("crt assertion failed");

`endif

>>> src/crt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types, widths and command codes of the CRT reconstruction block.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int PROD_W      = 64;  // modulus product and solution
  localparam int DIG_W       = 16;  // divisor / multiplier digit
  localparam int EU_W        = 18;  // signed Bezout coefficient
  localparam int MUL_CNT_W   = 2;   // PROD_W / DIG_W partial products
  localparam int DIV_STEPS_W = 7;
  localparam int ST_W        = 2;

  localparam logic [DIV_STEPS_W-1:0] DIV_LONG  = 7'd64;
  localparam logic [DIV_STEPS_W-1:0] DIV_MID   = 7'd32;
  localparam logic [DIV_STEPS_W-1:0] DIV_SHORT = 7'd16;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOCOPRIME = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] OP_SET_INIT = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV_B    = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV_BM   = 4'd4;
  localparam logic [OP_W-1:0] OP_EU_INIT  = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV_EU   = 4'd6;
  localparam logic [OP_W-1:0] OP_EU_UPD   = 4'd7;
  localparam logic [OP_W-1:0] OP_EU_FIN   = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_CP   = 4'd9;
  localparam logic [OP_W-1:0] OP_MUL_T    = 4'd10;
  localparam logic [OP_W-1:0] OP_ACC      = 4'd11;
  localparam logic [OP_W-1:0] OP_EMIT     = 4'd12;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ST_W-1:0] status;
  } crt_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic last_item;
    logic ovf;
    logic zero_mod;
    logic nr_zero;
    logic r_one;
    logic last_idx;
  } crt_sts_t;

endpackage

>>> src/crt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_div
// Restoring divider, one quotient bit per cycle, 16/32/64 steps.
// ----------------------------------------------------------------------------
module crt_div
  import crt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [PROD_W-1:0]      dividend,
  input  logic [DIG_W-1:0]       divisor,
  input  logic [DIV_STEPS_W-1:0] steps,
  output logic [PROD_W-1:0]      quo,
  output logic [DIG_W-1:0]       rem,
  output logic                   busy
);

  logic [PROD_W-1:0]      dvd_r, dvd_nxt;
  logic [DIG_W-1:0]       dsr_r;
  logic [DIG_W-1:0]       rem_r, rem_nxt;
  logic [DIV_STEPS_W-1:0] cnt_r;
  logic                   busy_r;
  logic [DIG_W:0]         rem_sh;
  logic                   ge;
  logic [DIV_STEPS_W-1:0] align;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[PROD_W-1]};
    ge      = rem_sh >= {1'b0, dsr_r};
    rem_nxt = ge ? DIG_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[DIG_W-1:0];
    dvd_nxt = {dvd_r[PROD_W-2:0], ge};
    align   = DIV_STEPS_W'(PROD_W) - steps;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      // operand sits in the top bits so the quotient lands in the low bits
      busy_r <= 1'b1;
      cnt_r  <= steps;
      dvd_r  <= dividend << align;
      dsr_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      dvd_r  <= dvd_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_r - 1'b1;
      if (cnt_r == DIV_STEPS_W'(1)) busy_r <= 1'b0;
    end
  end

  assign quo  = dvd_r;
  assign rem  = rem_r;
  assign busy = busy_r;

endmodule

>>> src/crt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_dp
// Pair store, modulus product, Euclid registers, shared divider/multiplier.
// ----------------------------------------------------------------------------
module crt_dp
  import crt_pkg::*;
#(
  parameter int MAX_PAIRS    = 4,
  parameter int MODULUS_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  crt_cmd_t          cmd,
  output crt_sts_t          sts,
  input  logic [DIG_W-1:0]  in_modulus,
  input  logic [DIG_W-1:0]  in_residue,
  input  logic              in_last,
  output logic              out_valid,
  output logic [PROD_W-1:0] out_solution,
  output logic [ST_W-1:0]   out_status
);

  localparam int CNT_W = $clog2(MAX_PAIRS + 1);
  localparam int IDX_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic [MODULUS_BITS-1:0] mod_mem [MAX_PAIRS];
  logic [DIG_W-1:0]        res_mem [MAX_PAIRS];
  logic [CNT_W-1:0]        count_r;
  logic [IDX_W-1:0]        idx_r;
  logic [PROD_W-1:0]       prod_r, b_r, term_r, sum_r, sum_nxt, room;
  logic                    ovf_r, last_r;
  logic [DIG_W-1:0]        eu_r_r, eu_nr_r, inv_r;
  logic signed [EU_W-1:0]  eu_t_r, eu_nt_r, t_adj;
  logic signed [DIG_W+EU_W:0] qnt;
  logic [DIG_W-1:0]        m_cur, res_cur, q;
  logic [2*DIG_W-1:0]      cp_prod;
  logic                    zero_mod;

  // shared multiplier: PROD_W x DIG_W as PROD_W/DIG_W partial products
  logic [PROD_W-1:0]    mul_a_r, mul_acc_r, mul_acc_nxt;
  logic [DIG_W-1:0]     mul_b_r;
  logic [MUL_CNT_W-1:0] mul_cnt_r;
  logic                 mul_busy_r, mul_dst_prod_r;
  logic [2*DIG_W-1:0]   pp;

  logic                   div_start, div_busy;
  logic [PROD_W-1:0]      div_dvd, div_quo;
  logic [DIG_W-1:0]       div_dsr, div_rem;
  logic [DIV_STEPS_W-1:0] div_steps;

  logic                    out_valid_r;
  logic [PROD_W-1:0]       out_solution_r;
  logic [ST_W-1:0]         out_status_r;

  always_comb begin
    m_cur    = DIG_W'(mod_mem[idx_r]);
    res_cur  = res_mem[idx_r];
    q        = div_quo[DIG_W-1:0];
    qnt      = $signed({1'b0, q}) * eu_nt_r;
    t_adj    = eu_t_r[EU_W-1] ? eu_t_r + $signed(EU_W'(m_cur)) : eu_t_r;
    cp_prod  = div_rem * inv_r;
    room     = prod_r - term_r;
    sum_nxt  = (sum_r >= room) ? sum_r - room : sum_r + term_r;
    pp       = mul_a_r[mul_cnt_r*DIG_W +: DIG_W] * mul_b_r;
    mul_acc_nxt = mul_acc_r + (PROD_W'(pp) << (32'(mul_cnt_r) * DIG_W));
    zero_mod = 1'b0;
    for (int i = 0; i < MAX_PAIRS; i++) begin
      if ((CNT_W'(i) < count_r) && (mod_mem[i] == '0)) zero_mod = 1'b1;
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = m_cur;
    div_steps = DIV_SHORT;
    unique case (cmd.op)
      OP_DIV_B: begin
        div_start = 1'b1;
        div_dvd   = prod_r;
        div_steps = DIV_LONG;
      end
      OP_DIV_BM: begin
        div_start = 1'b1;
        div_dvd   = div_quo;
        div_steps = DIV_LONG;
      end
      OP_DIV_EU: begin
        div_start = 1'b1;
        div_dvd   = PROD_W'(eu_r_r);
        div_dsr   = eu_nr_r;
      end
      OP_EU_FIN: begin
        div_start = 1'b1;
        div_dvd   = PROD_W'(res_cur);
      end
      OP_DIV_CP: begin
        div_start = 1'b1;
        div_dvd   = PROD_W'(cp_prod);
        div_steps = DIV_MID;
      end
      default: ;
    endcase
  end

  crt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .steps    (div_steps),
    .quo      (div_quo),
    .rem      (div_rem),
    .busy     (div_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      prod_r      <= PROD_W'(1);
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      mul_busy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (mul_busy_r) begin
        mul_acc_r <= mul_acc_nxt;
        mul_cnt_r <= mul_cnt_r + 1'b1;
        if (mul_cnt_r == '1) begin
          mul_busy_r <= 1'b0;
          if (mul_dst_prod_r) prod_r <= mul_acc_nxt;
          else                term_r <= mul_acc_nxt;
        end
      end
      unique case (cmd.op)
        OP_LOAD: begin
          last_r <= in_last;
          if (count_r < CNT_W'(MAX_PAIRS)) begin
            mod_mem[count_r[IDX_W-1:0]] <= in_modulus[MODULUS_BITS-1:0];
            res_mem[count_r[IDX_W-1:0]] <= in_residue;
            count_r        <= count_r + 1'b1;
            mul_busy_r     <= 1'b1;
            mul_dst_prod_r <= 1'b1;
            mul_a_r        <= prod_r;
            mul_b_r        <= DIG_W'(in_modulus[MODULUS_BITS-1:0]);
            mul_acc_r      <= '0;
            mul_cnt_r      <= '0;
          end else begin
            ovf_r <= 1'b1;
          end
        end
        OP_SET_INIT: begin
          sum_r <= '0;
          idx_r <= '0;
        end
        OP_DIV_BM: b_r <= div_quo;
        OP_EU_INIT: begin
          eu_r_r  <= m_cur;
          eu_nr_r <= div_rem;
          eu_t_r  <= '0;
          eu_nt_r <= EU_W'(1);
        end
        OP_EU_UPD: begin
          eu_t_r  <= eu_nt_r;
          eu_nt_r <= eu_t_r - qnt[EU_W-1:0];
          eu_r_r  <= eu_nr_r;
          eu_nr_r <= div_rem;
        end
        OP_EU_FIN: inv_r <= t_adj[DIG_W-1:0];
        OP_MUL_T: begin
          mul_busy_r     <= 1'b1;
          mul_dst_prod_r <= 1'b0;
          mul_a_r        <= b_r;
          mul_b_r        <= div_rem;
          mul_acc_r      <= '0;
          mul_cnt_r      <= '0;
        end
        OP_ACC: begin
          sum_r <= sum_nxt;
          idx_r <= idx_r + 1'b1;
        end
        OP_EMIT: begin
          out_valid_r    <= 1'b1;
          out_status_r   <= cmd.status;
          out_solution_r <= (cmd.status == ST_OK) ? sum_r : '0;
          count_r        <= '0;
          prod_r         <= PROD_W'(1);
          ovf_r          <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    sts.mul_busy  = mul_busy_r;
    sts.div_busy  = div_busy;
    sts.last_item = last_r;
    sts.ovf       = ovf_r;
    sts.zero_mod  = zero_mod;
    sts.nr_zero   = (eu_nr_r == '0);
    sts.r_one     = (eu_r_r == DIG_W'(1));
    sts.last_idx  = ((CNT_W'(idx_r) + 1'b1) == count_r);
  end

  assign out_valid    = out_valid_r;
  assign out_solution = out_solution_r;
  assign out_status   = out_status_r;

endmodule

>>> src/crt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer: load, checks, per-pair quotient, Euclid loop, coefficient, accumulate, emit.
// ----------------------------------------------------------------------------
module crt_ctrl
  import crt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  crt_sts_t sts,
  output crt_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOADW = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_DIVB  = 4'd3;
  localparam logic [3:0] S_WB    = 4'd4;
  localparam logic [3:0] S_WBM   = 4'd5;
  localparam logic [3:0] S_EUT   = 4'd6;
  localparam logic [3:0] S_WEU   = 4'd7;
  localparam logic [3:0] S_EUF   = 4'd8;
  localparam logic [3:0] S_WRES  = 4'd9;
  localparam logic [3:0] S_WCP   = 4'd10;
  localparam logic [3:0] S_WMT   = 4'd11;
  localparam logic [3:0] S_EMIT  = 4'd12;

  logic [3:0]      state_r, state_nxt;
  logic [ST_W-1:0] stat_r, stat_nxt;

  always_comb begin
    state_nxt  = state_r;
    stat_nxt   = stat_r;
    cmd.op     = OP_NONE;
    cmd.status = stat_r;
    unique case (state_r)
      S_IDLE: if (start) begin
        cmd.op    = OP_LOAD;
        state_nxt = S_LOADW;
      end
      S_LOADW: if (!sts.mul_busy) begin
        state_nxt = sts.last_item ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        if (sts.ovf) begin
          stat_nxt  = ST_OVERFLOW;
          state_nxt = S_EMIT;
        end else if (sts.zero_mod) begin
          stat_nxt  = ST_NOCOPRIME;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_SET_INIT;
          state_nxt = S_DIVB;
        end
      end
      S_DIVB: begin
        cmd.op    = OP_DIV_B;
        state_nxt = S_WB;
      end
      S_WB: if (!sts.div_busy) begin
        cmd.op    = OP_DIV_BM;
        state_nxt = S_WBM;
      end
      S_WBM: if (!sts.div_busy) begin
        cmd.op    = OP_EU_INIT;
        state_nxt = S_EUT;
      end
      S_EUT: begin
        if (sts.nr_zero) begin
          state_nxt = S_EUF;
        end else begin
          cmd.op    = OP_DIV_EU;
          state_nxt = S_WEU;
        end
      end
      S_WEU: if (!sts.div_busy) begin
        cmd.op    = OP_EU_UPD;
        state_nxt = S_EUT;
      end
      S_EUF: begin
        if (!sts.r_one) begin
          stat_nxt  = ST_NOCOPRIME;
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_EU_FIN;
          state_nxt = S_WRES;
        end
      end
      S_WRES: if (!sts.div_busy) begin
        cmd.op    = OP_DIV_CP;
        state_nxt = S_WCP;
      end
      S_WCP: if (!sts.div_busy) begin
        cmd.op    = OP_MUL_T;
        state_nxt = S_WMT;
      end
      S_WMT: if (!sts.mul_busy) begin
        cmd.op = OP_ACC;
        if (sts.last_idx) begin
          stat_nxt  = ST_OK;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_DIVB;
        end
      end
      S_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stat_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      stat_r  <= stat_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> src/crt_reconstruct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_reconstruct_core
// Chinese-remainder reconstruction over a set of (modulus, residue) pairs.
// ----------------------------------------------------------------------------
// Input: a pair is taken when start is high and busy is low. Each taken pair
// keeps busy high while the modulus product is updated by a 64x16 multiply
// done as four 16x16 partial products.
// A pair with in_last set closes the set. The block then works pair by pair
// on one shared restoring divider (one bit per cycle): M/m (64), b mod m (64),
// one 16-step division per extended-Euclid iteration (at most about 24
// iterations), r mod m (16), coefficient mod m (32), then a multiply done as
// four partial products and an accumulate.
// Result: out_valid is high for one cycle with out_solution and out_status,
// in the first cycle with busy low. The receiver cannot stall; the result is
// presented once. Status 2 (too many pairs) or 1 (zero or non-coprime modulus)
// gives solution 0; status 2 or a zero modulus skips the per-pair work.
// Reset (rst_n low, synchronous) empties the set: product 1, no pairs.
// ----------------------------------------------------------------------------
module crt_reconstruct_core
  import crt_pkg::*;
#(
  parameter int MAX_PAIRS    = 4,
  parameter int MODULUS_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [DIG_W-1:0]  in_modulus,
  input  logic [DIG_W-1:0]  in_residue,
  input  logic              in_last,
  output logic              out_valid,
  output logic [PROD_W-1:0] out_solution,
  output logic [ST_W-1:0]   out_status
);

  crt_cmd_t cmd;
  crt_sts_t sts;

  crt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  crt_dp #(
    .MAX_PAIRS    (MAX_PAIRS),
    .MODULUS_BITS (MODULUS_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_modulus   (in_modulus),
    .in_residue   (in_residue),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_solution (out_solution),
    .out_status   (out_status)
  );

endmodule

>>> src/crt_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_chk
// Port-level checks of the CRT reconstruction block, bound to the top level.
// ----------------------------------------------------------------------------
`include "crt_reconstruct_core_assert.svh"

module crt_chk
  import crt_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic [DIG_W-1:0]  in_modulus,
  input logic [DIG_W-1:0]  in_residue,
  input logic              in_last,
  input logic              out_valid,
  input logic [PROD_W-1:0] out_solution,
  input logic [ST_W-1:0]   out_status
);

  // error results carry no solution
  `CRT_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid && (out_status != ST_OK), out_solution == '0)
  // a taken item always occupies the block
  `CRT_ASSERT_NXT(a_take_busy, clk, rst_n, start && !busy, busy)
  // never two results in a row
  `CRT_ASSERT_NXT(a_single, clk, rst_n, out_valid, !out_valid)
  // a result closes a busy period
  `CRT_ASSERT_NOW(a_after_busy, clk, rst_n, out_valid, $past(busy) && !busy)

endmodule

bind crt_reconstruct_core crt_chk u_crt_chk (.*);

>>> tb/tb_crt_reconstruct_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crt_reconstruct_core
// Self-checking bench for the CRT reconstruction core.
// ----------------------------------------------------------------------------
// Sets of (modulus, residue) pairs are queued by an initial block and sent
// in random bursts. An in-bench CRT solver follows every taken pair and
// predicts the solution and status of each closed set; the monitor compares
// every out_valid cycle against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_crt_reconstruct_core;
  import crt_pkg::*;

  localparam int  SLOTS       = 4;
  localparam longint CYC_LIMIT = 12_000_000;

  typedef struct {
    logic [15:0] modulus;
    logic [15:0] residue;
    logic        last;
    bit          drain;   // hold until all answers are back
  } pair_t;

  typedef struct {
    logic [63:0]     solution;
    logic [ST_W-1:0] status;
  } answer_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [DIG_W-1:0]  in_modulus;
  logic [DIG_W-1:0]  in_residue;
  logic              in_last;
  logic              out_valid;
  logic [PROD_W-1:0] out_solution;
  logic [ST_W-1:0]   out_status;

  crt_reconstruct_core #(.MAX_PAIRS(SLOTS), .MODULUS_BITS(16)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_modulus(in_modulus), .in_residue(in_residue), .in_last(in_last),
    .out_valid(out_valid), .out_solution(out_solution), .out_status(out_status)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  pair_t   pair_q[$];
  answer_t answer_q[$];
  bit      gen_done;
  int      errors, mism, checked, n_ok, n_nocop, n_ovf;
  longint  cycles;

  // solver state
  logic [15:0] st_mod[SLOTS];
  logic [15:0] st_res[SLOTS];
  int          st_cnt;
  logic [63:0] st_prod;
  bit          st_ovf;

  function automatic int gcd16(int a, int b);
    int t;
    while (b != 0) begin
      t = a % b; a = b; b = t;
    end
    return a;
  endfunction

  function automatic bit mod_inverse(longint unsigned val, longint unsigned m,
                                     output longint unsigned inv);
    longint t, nt, r, nr, q, tmp;
    t = 0; nt = 1; r = longint'(m); nr = longint'(val % m);
    while (nr != 0) begin
      q = r / nr;
      tmp = t - q * nt; t = nt; nt = tmp;
      tmp = r - q * nr; r = nr; nr = tmp;
    end
    if (r != 1) return 1'b0;
    if (t < 0) t += longint'(m);
    inv = longint'(t) % m;
    return 1'b1;
  endfunction

  task automatic fold_pair(logic [15:0] m_in, logic [15:0] r_in, logic lst);
    answer_t a;
    longint unsigned m, b, inv, coef, sum, room, term;
    if (st_cnt < SLOTS) begin
      st_mod[st_cnt] = m_in;
      st_res[st_cnt] = r_in;
      st_cnt++;
      st_prod = st_prod * m_in;
    end else begin
      st_ovf = 1'b1;
    end
    if (!lst) return;
    sum = 0;
    a.status = ST_OK;
    if (st_ovf) begin
      a.status = ST_OVERFLOW;
    end else begin
      for (int i = 0; i < st_cnt; i++)
        if (st_mod[i] == 0) a.status = ST_NOCOPRIME;
      for (int i = 0; a.status == ST_OK && i < st_cnt; i++) begin
        m = st_mod[i];
        b = st_prod / m;
        if (!mod_inverse(b, m, inv)) begin
          a.status = ST_NOCOPRIME;
        end else begin
          coef = ((st_res[i] % m) * inv) % m;
          term = b * coef;
          room = st_prod - term;
          sum = (sum >= room) ? sum - room : sum + term;
        end
      end
    end
    a.solution = (a.status == ST_OK) ? sum : 64'd0;
    answer_q.push_back(a);
    st_cnt = 0; st_prod = 64'd1; st_ovf = 1'b0;
  endtask

  // ---------------- stimulus generation ----------------
  task automatic queue_set(logic [15:0] mods[$], bit drain);
    pair_t p;
    foreach (mods[i]) begin
      p.modulus = mods[i];
      p.residue = 16'($urandom_range(0, 65535));
      p.last    = (i == mods.size() - 1);
      p.drain   = drain && (i == 0);
      pair_q.push_back(p);
    end
  endtask

  function automatic logic [15:0] rand_mod();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(1, 40));
      1: return 16'($urandom_range(1, 1000));
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic coprime_set(int n, output logic [15:0] mods[$]);
    logic [15:0] c;
    bit ok;
    mods = {};
    while (mods.size() < n) begin
      for (int t = 0; t < 60; t++) begin
        c = rand_mod();
        ok = 1'b1;
        foreach (mods[j]) if (gcd16(c, mods[j]) != 1) ok = 1'b0;
        if (ok) break;
      end
      if (!ok) c = 16'd1;
      mods.push_back(c);
    end
  endtask

  initial begin
    logic [15:0] mods[$];
    int k, n;
    pair_t p;
    gen_done = 0;
    // directed sets
    mods = {16'd65535, 16'd65534, 16'd65533, 16'd65521}; queue_set(mods, 0);
    p.modulus = 16'd7; p.residue = 16'd65535; p.last = 1; p.drain = 0;
    pair_q.push_back(p);
    mods = {16'd1};                      queue_set(mods, 0);
    mods = {16'd1, 16'd5, 16'd1};        queue_set(mods, 0);
    mods = {16'd6, 16'd4};               queue_set(mods, 1);
    mods = {16'd3, 16'd0, 16'd5};        queue_set(mods, 0);
    mods = {16'd0};                      queue_set(mods, 0);
    mods = {16'd2, 16'd3, 16'd5, 16'd7, 16'd11}; queue_set(mods, 0);
    mods = {16'd6, 16'd4, 16'd9, 16'd8, 16'd10, 16'd0}; queue_set(mods, 1);
    mods = {16'd32768, 16'd32767};       queue_set(mods, 0);
    // random sets
    while (pair_q.size() < 1400) begin
      k = $urandom_range(0, 99);
      n = $urandom_range(1, 4);
      if (k < 68) begin
        coprime_set(n, mods);
      end else if (k < 80) begin
        mods = {};
        repeat (n) mods.push_back(rand_mod());
      end else if (k < 88) begin
        mods = {};
        repeat ($urandom_range(5, 7)) mods.push_back(16'($urandom_range(0, 65535)));
      end else if (k < 93) begin
        coprime_set(n, mods);
        mods[$urandom_range(0, n - 1)] = 16'd0;
      end else begin
        coprime_set(n, mods);
        mods[$urandom_range(0, n - 1)] = 16'd1;
      end
      queue_set(mods, $urandom_range(0, 39) == 0);
    end
    gen_done = 1;
  end

  // ---------------- reset / driver ----------------
  bit took;
  int burst_left, gap_left;

  initial begin
    rst_n = 1'b0; start = 1'b0;
    in_modulus = '0; in_residue = '0; in_last = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    took <= rst_n && start && !busy;
    if (rst_n && start && !busy) fold_pair(in_modulus, in_residue, in_last);
  end

  initial begin
    burst_left = 4; gap_left = 0;
    st_cnt = 0; st_prod = 64'd1; st_ovf = 1'b0;
  end

  always @(negedge clk) begin
    pair_t p;
    if (rst_n && gen_done && (!start || took)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pair_q.size() != 0 &&
                   !(pair_q[0].drain && (answer_q.size() != 0 || busy))) begin
        p = pair_q.pop_front();
        in_modulus <= p.modulus;
        in_residue <= p.residue;
        in_last    <= p.last;
        start      <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 3);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        errors++;
        if (mism < 10)
          $display("unexpected result: solution=%0d status=%0d", out_solution, out_status);
        mism++;
      end else begin
        e = answer_q.pop_front();
        checked++;
        case (e.status)
          ST_OK:        n_ok++;
          ST_NOCOPRIME: n_nocop++;
          default:      n_ovf++;
        endcase
        if (out_solution !== e.solution || out_status !== e.status) begin
          errors++;
          if (mism < 10)
            $display("mismatch #%0d: solution exp=%0d got=%0d, status exp=%0d got=%0d",
                     checked, e.solution, out_solution, e.status, out_status);
          mism++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    errors = 0; mism = 0; checked = 0; cycles = 0;
    n_ok = 0; n_nocop = 0; n_ovf = 0;
    wait (gen_done);
    // check at clock edges so a pair popped at the falling edge is seen as sent
    @(posedge clk);
    while (pair_q.size() != 0 || start || answer_q.size() != 0 || busy) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("checked %0d sets: %0d solved, %0d not coprime or zero, %0d over capacity",
             checked, n_ok, n_nocop, n_ovf);
    $display("%0d mismatches over %0d cycles", mism, cycles);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/crt_pkg.sv
src/crt_div.sv
src/crt_dp.sv
src/crt_ctrl.sv
src/crt_reconstruct_core.sv
src/crt_chk.sv
tb/tb_crt_reconstruct_core.sv
